[design/alu8_pkg.sv]
package alu8_pkg;

    localparam int DATA_W      = 8;
    localparam int FUNC_W      = 4;
    localparam int NUM_CELLS   = DATA_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [FUNC_W-1:0] OP_ADD = 4'd0;
    localparam logic [FUNC_W-1:0] OP_SUB = 4'd1;
    localparam logic [FUNC_W-1:0] OP_MUL = 4'd2;
    localparam logic [FUNC_W-1:0] OP_DIV = 4'd3;
    localparam logic [FUNC_W-1:0] OP_MOD = 4'd4;
    localparam logic [FUNC_W-1:0] OP_INC = 4'd5;
    localparam logic [FUNC_W-1:0] OP_DEC = 4'd6;
    localparam logic [FUNC_W-1:0] OP_AND = 4'd7;
    localparam logic [FUNC_W-1:0] OP_OR  = 4'd8;
    localparam logic [FUNC_W-1:0] OP_XOR = 4'd9;
    localparam logic [FUNC_W-1:0] OP_NOT = 4'd10;
    localparam logic [FUNC_W-1:0] OP_SHL = 4'd11;
    localparam logic [FUNC_W-1:0] OP_SHR = 4'd12;
    localparam logic [FUNC_W-1:0] OP_CMP = 4'd13;

    // one request as it travels down the divider chain
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] quo;     // dividend bits shift out high, quotient bits in low
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] res;     // result of the operations other than divide and modulo
        logic              cy;
        logic              wr;
    } stage_t;

endpackage

[design/alu_8bit_with_flags.sv]
// channel   | dir | signals              | payload
// s_axis    | in  | tvalid tready tdata  | func, a_value, b_value
// m_axis    | out | tvalid tready tdata  | result_value, writes_accumulator, flags
//
// one request per cycle while not stalled; a request passes eight divider cells,
// each resolving one quotient bit, then the output register
// the whole chain moves together; it stalls only while the output
// register holds a result that m_axis has not taken
// reset clears the valid bits of the cells and of the output register
module alu_8bit_with_flags
    import alu8_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // func[3:0], a_value[11:4], b_value[19:12]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result_value[7:0], writes_accumulator[8],
                                                   // carry_flag[9], zero_flag[10],
                                                   // negative_flag[11]
);

    logic                   advance;
    logic                   cell_valid [0:NUM_CELLS];
    stage_t                 cell_stage [0:NUM_CELLS];
    stage_t                 last;
    logic [DATA_W-1:0]      fin_res;
    logic                   fin_cy;
    logic                   fin_neg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    assign advance       = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = advance;

    alu8_front u_front (
        .func    (s_axis_tdata[FUNC_W-1:0]),
        .a_value (s_axis_tdata[FUNC_W+DATA_W-1:FUNC_W]),
        .b_value (s_axis_tdata[FUNC_W+2*DATA_W-1:FUNC_W+DATA_W]),
        .stage   (cell_stage[0])
    );
    assign cell_valid[0] = s_axis_tvalid;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        alu8_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (cell_valid[i]),
            .in_stage  (cell_stage[i]),
            .out_valid (cell_valid[i+1]),
            .out_stage (cell_stage[i+1])
        );
    end

    assign last = cell_stage[NUM_CELLS];

    always_comb
    begin
        fin_res = last.res;
        fin_cy  = last.cy;
        fin_neg = 1'b1;
        if (last.func == OP_DIV || last.func == OP_MOD)
        begin
            if (last.divisor == '0)
            begin
                fin_res = '0;
                fin_cy  = 1'b1;
            end
            else
            begin
                fin_res = (last.func == OP_DIV) ? last.quo : last.rem;
                fin_cy  = 1'b0;
            end
            fin_neg = (last.func == OP_DIV);
        end
        out_data_next = '0;
        out_data_next[DATA_W-1:0] = fin_res;
        out_data_next[DATA_W]     = last.wr;
        out_data_next[DATA_W+1]   = fin_cy;
        out_data_next[DATA_W+2]   = (fin_res == '0);
        out_data_next[DATA_W+3]   = fin_neg & fin_res[DATA_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cell_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[design/alu8_front.sv]
module alu8_front
    import alu8_pkg::*;
(
    input  logic [FUNC_W-1:0] func,
    input  logic [DATA_W-1:0] a_value,
    input  logic [DATA_W-1:0] b_value,
    output stage_t            stage
);

    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0]     sum;
    logic [DATA_W:0]     diff;
    logic [DATA_W:0]     incr;
    logic [DATA_W:0]     decr;

    assign prod = a_value * b_value;
    assign sum  = {1'b0, a_value} + {1'b0, b_value};
    assign diff = {1'b0, a_value} - {1'b0, b_value};
    assign incr = {1'b0, a_value} + {{DATA_W{1'b0}}, 1'b1};
    assign decr = {1'b0, a_value} - {{DATA_W{1'b0}}, 1'b1};

    always_comb
    begin
        stage.func    = func;
        stage.divisor = b_value;
        stage.quo     = a_value;
        stage.rem     = '0;
        stage.res     = '0;
        stage.cy      = 1'b0;
        stage.wr      = 1'b1;
        unique case (func)
            OP_ADD:
            begin
                stage.res = sum[DATA_W-1:0];
                stage.cy  = sum[DATA_W];
            end
            OP_SUB:
            begin
                stage.res = diff[DATA_W-1:0];
                stage.cy  = diff[DATA_W];
            end
            OP_MUL:
            begin
                stage.res = prod[DATA_W-1:0];
                stage.cy  = |prod[2*DATA_W-1:DATA_W];
            end
            OP_DIV, OP_MOD:
            begin
                stage.res = '0;
            end
            OP_INC:
            begin
                stage.res = incr[DATA_W-1:0];
                stage.cy  = incr[DATA_W];
            end
            OP_DEC:
            begin
                stage.res = decr[DATA_W-1:0];
                stage.cy  = decr[DATA_W];
            end
            OP_AND: stage.res = a_value & b_value;
            OP_OR:  stage.res = a_value | b_value;
            OP_XOR: stage.res = a_value ^ b_value;
            OP_NOT: stage.res = ~a_value;
            OP_SHL:
            begin
                stage.res = {a_value[DATA_W-2:0], 1'b0};
                stage.cy  = a_value[DATA_W-1];
            end
            OP_SHR:
            begin
                stage.res = {1'b0, a_value[DATA_W-1:1]};
                stage.cy  = a_value[0];
            end
            OP_CMP:
            begin
                stage.res = diff[DATA_W-1:0];
                stage.cy  = diff[DATA_W];
                stage.wr  = 1'b0;
            end
            default:
            begin
                stage.res = '0;
                stage.wr  = 1'b0;
            end
        endcase
    end

endmodule

[design/alu8_div_cell.sv]
module alu8_div_cell
    import alu8_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    logic            valid_reg;
    stage_t          stage_reg;
    stage_t          stage_next;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] trial_diff;
    logic            fits;

    // one restoring division step: bring down the next dividend bit
    assign trial      = {in_stage.rem, in_stage.quo[DATA_W-1]};
    assign trial_diff = trial - {1'b0, in_stage.divisor};
    assign fits       = ~trial_diff[DATA_W];

    always_comb
    begin
        stage_next     = in_stage;
        stage_next.quo = {in_stage.quo[DATA_W-2:0], fits};
        stage_next.rem = fits ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

[design/alu8_checker.sv]
module alu8_checker
    import alu8_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a result held back by the sink stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the chain only stalls on a full output register
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[DATA_W+2] == (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("zero flag disagrees with result");

    a_neg_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[DATA_W+3] |-> m_axis_tdata[DATA_W-1])
        else $error("negative flag without bit 7");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:DATA_W+4] == '0)
        else $error("padding bits set");

endmodule

bind alu_8bit_with_flags alu8_checker u_alu8_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
